// ----- rtl/bbc_pkg.sv -----
// Shared types, constants and helpers for the bracket balance checker.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
package bbc_pkg;

    // Sizing
    localparam int STACK_DEPTH   = 32;
    localparam int POSITION_BITS = 16;
    localparam int FILL_W        = $clog2(STACK_DEPTH + 1);
    localparam int REPORT_POS_W  = 16;

    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

    // Bracket kind codes: openers below closers, closer = opener + 3
    localparam logic [2:0] KIND_OPEN_PAREN   = 3'd0;
    localparam logic [2:0] KIND_OPEN_SQUARE  = 3'd1;
    localparam logic [2:0] KIND_OPEN_CURLY   = 3'd2;
    localparam logic [2:0] KIND_CLOSE_PAREN  = 3'd3;
    localparam logic [2:0] KIND_CLOSE_SQUARE = 3'd4;
    localparam logic [2:0] KIND_CLOSE_CURLY  = 3'd5;
    localparam logic [2:0] KIND_NONE         = 3'd7;

    // Character codes
    localparam logic [7:0] CHAR_OPEN_PAREN   = 8'h28;
    localparam logic [7:0] CHAR_OPEN_SQUARE  = 8'h5B;
    localparam logic [7:0] CHAR_OPEN_CURLY   = 8'h7B;
    localparam logic [7:0] CHAR_CLOSE_PAREN  = 8'h29;
    localparam logic [7:0] CHAR_CLOSE_SQUARE = 8'h5D;
    localparam logic [7:0] CHAR_CLOSE_CURLY  = 8'h7D;
    localparam logic [7:0] CHAR_NEWLINE      = 8'h0A;

    // Report kind codes
    localparam logic [1:0] REPORT_CLEAN    = 2'd0;
    localparam logic [1:0] REPORT_ERRORS   = 2'd1;
    localparam logic [1:0] REPORT_MISSING  = 2'd2;
    localparam logic [1:0] REPORT_MISMATCH = 2'd3;

    typedef struct packed {
        logic [7:0] symbol;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [1:0]              report_kind;
        logic [REPORT_POS_W-1:0] report_line;
        logic [REPORT_POS_W-1:0] report_column;
        logic                    overflowed;
        logic                    last_report;
    } t_out_item;

    // One stack record
    typedef struct packed {
        logic [2:0]               kind;
        logic [POSITION_BITS-1:0] line;
        logic [POSITION_BITS-1:0] column;
    } t_entry;

    // Shift command broadcast to every cell
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctrl;

    function automatic logic [2:0] kind_of(input logic [7:0] ch);
        logic [2:0] k;
        case (ch)
            CHAR_OPEN_PAREN:   k = KIND_OPEN_PAREN;
            CHAR_OPEN_SQUARE:  k = KIND_OPEN_SQUARE;
            CHAR_OPEN_CURLY:   k = KIND_OPEN_CURLY;
            CHAR_CLOSE_PAREN:  k = KIND_CLOSE_PAREN;
            CHAR_CLOSE_SQUARE: k = KIND_CLOSE_SQUARE;
            CHAR_CLOSE_CURLY:  k = KIND_CLOSE_CURLY;
            default:           k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic logic is_opener(input logic [2:0] k);
        return k < KIND_CLOSE_PAREN;
    endfunction

    // Fit a position onto the report field: zero-extend or keep low bits
    function automatic logic [REPORT_POS_W-1:0] to_report(
        input logic [POSITION_BITS-1:0] pos
    );
        logic [POSITION_BITS+REPORT_POS_W-1:0] wide;
        wide = (POSITION_BITS + REPORT_POS_W)'(pos);
        return wide[REPORT_POS_W-1:0];
    endfunction

endpackage

// ----- rtl/bracket_balance_checker.sv -----
// Top level of the bracket balance checker: position counters, push/pop
// control, end-of-text report sequencer and output register.
// Depends on bbc_pkg and bbc_stack_cell.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) takes one character
//   per transaction, or an end-of-text marker. A character gives no result;
//   it updates line/column and, for a bracket, pushes or pops the stack,
//   one character per cycle while no report runs. The stack is a row of
//   STACK_DEPTH cells, cell 0 the top, shifting all records one place on
//   each push or pop. End of text: o_in_ready drops while the report runs.
//   The summary is loaded first, then each cycle pops one record off
//   cell 0, an opener only once the output slot is free; an opener becomes
//   a report, a closer only bumps the pending-closer count. The run ends
//   with the summary if no opener is left, else after the last opener;
//   that result is flagged last_report, line/column and fill are back to
//   their start values and the next character is taken in the following
//   cycle. Output channel (o_out_valid / i_out_ready / o_out_item) is fed
//   from one output register; a stall holds the result there and pauses
//   summary and opener reports, while closers drain and later input flows.
//   Reset (i_rst_n low, synchronous): empty stack, line 1, column 0, no
//   result pending. Stack records are not cleared.
module bracket_balance_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  bbc_pkg::t_in_item i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output bbc_pkg::t_out_item o_out_item
);

    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_SUMMARY = 2'd1;
    localparam logic [1:0] ST_DRAIN   = 2'd2;

    localparam int DEPTH = bbc_pkg::STACK_DEPTH;
    localparam int FW    = bbc_pkg::FILL_W;
    localparam int PW    = bbc_pkg::POSITION_BITS;

    logic [1:0]         r_state,   n_state;
    logic [FW-1:0]      r_fill,    n_fill;
    logic [FW-1:0]      r_pending, n_pending;
    logic [PW-1:0]      r_line,    n_line;
    logic [PW-1:0]      r_column,  n_column;
    logic               r_ovf,     n_ovf;
    logic               r_run_ovf, n_run_ovf;
    logic               r_out_valid, n_out_valid;
    bbc_pkg::t_out_item r_out_item, n_out_item;

    bbc_pkg::t_cell_ctrl w_ctrl;
    bbc_pkg::t_entry     w_push_entry;
    bbc_pkg::t_entry     w_cell_entry [DEPTH];
    logic [DEPTH-1:0]    w_cell_opener;

    logic       w_accept;
    logic       w_slot_free;
    logic [2:0] w_kind;
    logic       w_any_opener;
    logic       w_opener_below;
    logic       w_load;
    bbc_pkg::t_entry w_top;

    assign w_accept       = i_in_valid && o_in_ready;
    assign w_slot_free    = !r_out_valid || i_out_ready;
    assign w_kind         = bbc_pkg::kind_of(i_in_item.symbol);
    assign w_any_opener   = |w_cell_opener;
    assign w_opener_below = |w_cell_opener[DEPTH-1:1];
    assign w_top          = w_cell_entry[0];

    // Row of stack cells
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        bbc_pkg::t_entry w_above;
        bbc_pkg::t_entry w_below;
        if (gi == 0) begin : g_top
            assign w_above = w_push_entry;
        end else begin : g_mid
            assign w_above = w_cell_entry[gi-1];
        end
        if (gi == DEPTH - 1) begin : g_bottom
            assign w_below = w_cell_entry[gi];
        end else begin : g_upper
            assign w_below = w_cell_entry[gi+1];
        end
        bbc_stack_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (w_ctrl),
            .i_from_above (w_above),
            .i_from_below (w_below),
            .i_live       (FW'(gi) < r_fill),
            .o_entry      (w_cell_entry[gi]),
            .o_opener     (w_cell_opener[gi])
        );
    end

    // Character handling and report sequencing
    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_pending    = r_pending;
        n_line       = r_line;
        n_column     = r_column;
        n_ovf        = r_ovf;
        n_run_ovf    = r_run_ovf;
        w_ctrl       = '0;
        w_load       = 1'b0;
        n_out_item   = r_out_item;
        w_push_entry = '0;

        // Advance position for a character
        if (i_in_item.symbol == bbc_pkg::CHAR_NEWLINE) begin
            w_push_entry.line   = (r_line < bbc_pkg::POS_MAX) ? r_line + bbc_pkg::POS_ONE
                                                              : r_line;
            w_push_entry.column = bbc_pkg::POS_ONE;
        end else begin
            w_push_entry.line   = r_line;
            w_push_entry.column = (r_column < bbc_pkg::POS_MAX)
                                  ? r_column + bbc_pkg::POS_ONE : r_column;
        end
        w_push_entry.kind = w_kind;

        case (r_state)
            ST_IDLE: begin
                if (w_accept && i_in_item.end_of_text) begin
                    // Start the report run; counters restart now
                    n_run_ovf = r_ovf;
                    n_ovf     = 1'b0;
                    n_line    = bbc_pkg::POS_ONE;
                    n_column  = '0;
                    n_state   = ST_SUMMARY;
                end else if (w_accept) begin
                    n_line   = w_push_entry.line;
                    n_column = w_push_entry.column;
                    if (w_kind != bbc_pkg::KIND_NONE) begin
                        if (!bbc_pkg::is_opener(w_kind) && (r_fill != '0) &&
                            (w_top.kind == 3'(w_kind - bbc_pkg::KIND_CLOSE_PAREN))) begin
                            // Matching closer: drop the opener
                            w_ctrl.pop = 1'b1;
                            n_fill     = r_fill - FW'(1);
                        end else if (r_fill < FW'(DEPTH)) begin
                            w_ctrl.push = 1'b1;
                            n_fill      = r_fill + FW'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                end
            end
            ST_SUMMARY: begin
                if (w_slot_free) begin
                    w_load                   = 1'b1;
                    n_out_item.report_kind   = (r_fill == '0) ? bbc_pkg::REPORT_CLEAN
                                                              : bbc_pkg::REPORT_ERRORS;
                    n_out_item.report_line   = '0;
                    n_out_item.report_column = '0;
                    n_out_item.overflowed    = r_run_ovf;
                    n_out_item.last_report   = !w_any_opener;
                    n_pending                = '0;
                    if (!w_any_opener) begin
                        n_fill  = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (!bbc_pkg::is_opener(w_top.kind)) begin
                    // Closer: count it, no report
                    w_ctrl.pop = 1'b1;
                    n_fill     = r_fill - FW'(1);
                    n_pending  = r_pending + FW'(1);
                end else if (w_slot_free) begin
                    w_load                   = 1'b1;
                    w_ctrl.pop               = 1'b1;
                    n_fill                   = r_fill - FW'(1);
                    n_out_item.report_kind   = (r_pending == '0) ? bbc_pkg::REPORT_MISSING
                                                                 : bbc_pkg::REPORT_MISMATCH;
                    n_out_item.report_line   = bbc_pkg::to_report(w_top.line);
                    n_out_item.report_column = bbc_pkg::to_report(w_top.column);
                    n_out_item.overflowed    = r_run_ovf;
                    n_out_item.last_report   = !w_opener_below;
                    if (r_pending != '0) begin
                        n_pending = r_pending - FW'(1);
                    end
                    if (!w_opener_below) begin
                        // Remaining closers are not reported
                        n_fill  = '0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Output register valid
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_pending   <= '0;
            r_line      <= bbc_pkg::POS_ONE;
            r_column    <= '0;
            r_ovf       <= 1'b0;
            r_run_ovf   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_pending   <= n_pending;
            r_line      <= n_line;
            r_column    <= n_column;
            r_ovf       <= n_ovf;
            r_run_ovf   <= n_run_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(DEPTH))
        else $error("stack fill beyond depth");

    a_drain_has_opener: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> w_any_opener)
        else $error("report run without an opener left");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && n_out_item.last_report) |=> (r_state == ST_IDLE && r_fill == '0))
        else $error("last report did not end the run");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> w_slot_free)
        else $error("result loaded over a stalled result");

endmodule

// ----- rtl/bbc_stack_cell.sv -----
// One cell of the shifting bracket stack: holds a single record.
// Depends on bbc_pkg for the record and shift command types.
module bbc_stack_cell (
    input  logic               i_clk,
    input  bbc_pkg::t_cell_ctrl i_ctrl,
    input  bbc_pkg::t_entry    i_from_above,
    input  bbc_pkg::t_entry    i_from_below,
    input  logic               i_live,
    output bbc_pkg::t_entry    o_entry,
    output logic               o_opener
);

    bbc_pkg::t_entry r_entry;

    // Shift down on push, up on pop, else hold
    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_entry <= i_from_above;
        end else if (i_ctrl.pop) begin
            r_entry <= i_from_below;
        end
    end

    // Flag an occupied cell that holds an opener
    assign o_opener = i_live && bbc_pkg::is_opener(r_entry.kind);
    assign o_entry  = r_entry;

endmodule
